// File: rtl/srovc_pkg.sv
// ----------------------------------------------------------------------------
// Segment overlap counter package
// Shared widths, codes and types for the segment raster overlap counter.
// ----------------------------------------------------------------------------
package srovc_pkg;

	// Width of each coordinate field on the input stream.
	localparam int FIELD_W     = 10;
	// Width of the running overlap count.
	localparam int CNT_W       = 21;
	// Stream widths; the tdata payloads are padded to whole bytes.
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 1;
	// Per-cell hit counter.
	localparam int HIT_W       = 2;

	typedef logic [HIT_W-1:0] hit_t;
	typedef logic [CNT_W-1:0] count_t;

	localparam hit_t HIT_ONE = 2'd1;
	localparam hit_t HIT_SAT = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} ctrl_state_t;

endpackage

// File: rtl/segment_raster_overlap_counter.sv
// ----------------------------------------------------------------------------
// Segment raster overlap counter
// Draws line segments into a grid of saturating hit counters held in a
// memory and reports the running number of cells hit at least twice.
// ----------------------------------------------------------------------------
// Flow: a drawn segment of n cells, n = max(|dx|, |dy|) + 1, passes through
// the WALK, DRAIN and FINISH states before its result beat is loaded; a
// skipped segment goes from IDLE straight to FINISH. One segment is taken at
// a time, with one grid-memory read-modify-write per cell.
// Reset: after arst_n is released, a clearing pass writes zero to all
// 2^(2*COORD_BITS) cells, one per cycle, before the first segment is taken.
module segment_raster_overlap_counter
	import srovc_pkg::*;
#(
	parameter int COORD_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// start_x, start_y, end_x, end_y (10 bits each), from the lowest bit up
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// overlap_cells (21 bits), then zero padding
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// segment_skipped
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);

	localparam int ADDR_W = 2 * COORD_BITS;

	logic              rd_valid, clr_we;
	logic [ADDR_W-1:0] rd_addr, clr_addr;
	count_t            count, m_count;
	logic              m_skipped;
	logic              mem_re, mem_we;
	logic [ADDR_W-1:0] mem_raddr, mem_waddr;
	hit_t              mem_rdata, mem_wdata;

	srovc_ctrl #(
		.COORD_BITS(COORD_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_count      (m_count),
		.m_skipped    (m_skipped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.rd_valid     (rd_valid),
		.rd_addr      (rd_addr),
		.clr_we       (clr_we),
		.clr_addr     (clr_addr),
		.count        (count)
	);

	srovc_rmw #(
		.ADDR_W(ADDR_W)
	) u_rmw (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (rd_valid),
		.rd_addr  (rd_addr),
		.clr_we   (clr_we),
		.clr_addr (clr_addr),
		.mem_rdata(mem_rdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.count    (count)
	);

	srovc_grid_mem #(
		.ADDR_W(ADDR_W),
		.DATA_W(HIT_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - CNT_W)'(0), m_count};
	assign m_axis_tuser = OUT_TUSER_W'(m_skipped);

endmodule

// File: rtl/srovc_grid_mem.sv
// ----------------------------------------------------------------------------
// Grid memory
// Simple dual-port memory holding the per-cell hit counters, one write port
// and one read port with registered read data.
// ----------------------------------------------------------------------------
module srovc_grid_mem #(
	parameter int ADDR_W = 20,
	parameter int DATA_W = 2
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/srovc_rmw.sv
// ----------------------------------------------------------------------------
// Hit counter read-modify-write stage
// Takes the read data of the grid memory in the cycle after each cell read,
// bumps the saturating counter, writes it back and keeps the overlap count.
// ----------------------------------------------------------------------------
module srovc_rmw
	import srovc_pkg::*;
#(
	parameter int ADDR_W = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_valid,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              clr_we,
	input  logic [ADDR_W-1:0] clr_addr,
	input  hit_t              mem_rdata,
	output logic              mem_re,
	output logic [ADDR_W-1:0] mem_raddr,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_waddr,
	output hit_t              mem_wdata,
	output count_t            count
);

	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              bump;
	count_t            count_q;

	assign mem_re    = rd_valid;
	assign mem_raddr = rd_addr;

	// Cells within one segment are all distinct, so a write never collides
	// with the read issued in the same cycle.
	assign bump      = valid_s1 && (mem_rdata < HIT_SAT);
	assign mem_we    = clr_we | bump;
	assign mem_waddr = clr_we ? clr_addr : addr_s1;
	assign mem_wdata = clr_we ? hit_t'(0) : hit_t'(mem_rdata + HIT_ONE);
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q  <= '0;
		end else begin
			valid_s1 <= rd_valid;
			if (valid_s1 && (mem_rdata == HIT_ONE)) begin
				count_q <= count_q + count_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
	end

endmodule

// File: rtl/srovc_ctrl.sv
// ----------------------------------------------------------------------------
// Segment walk controller
// Runs the clearing pass, accepts segments, steps the walk one cell a cycle
// and holds the result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module srovc_ctrl
	import srovc_pkg::*;
#(
	parameter int COORD_BITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output count_t                  m_count,
	output logic                    m_skipped,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data,
	output logic                    rd_valid,
	output logic [2*COORD_BITS-1:0] rd_addr,
	output logic                    clr_we,
	output logic [2*COORD_BITS-1:0] clr_addr,
	input  count_t                  count
);

	localparam int ADDR_W = 2 * COORD_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;

	ctrl_state_t       state_q, state_d;
	coord_t            cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              walk_all_q;
	logic              out_valid_q;
	count_t            out_cnt_q;
	logic              out_skip_q;
	logic              skip_q;

	coord_t in_sx, in_sy, in_ex, in_ey;
	logic   in_accept, is_skip, at_end, slot_free, load_out;

	assign in_sx = COORD_BITS'(s_axis_tdata[FIELD_W-1:0]);
	assign in_sy = COORD_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
	assign in_ex = COORD_BITS'(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
	assign in_ey = COORD_BITS'(s_axis_tdata[4*FIELD_W-1:3*FIELD_W]);

	assign in_accept = s_axis_tvalid & s_axis_tready;
	assign is_skip   = !walk_all_q && (in_sx != in_ex) && (in_sy != in_ey);
	assign at_end    = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
	assign slot_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_accept) state_d = is_skip ? ST_FINISH : ST_WALK;
			end
			ST_WALK: begin
				if (at_end) state_d = ST_DRAIN;
			end
			// The last cell's write-back and count update land in this cycle.
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		rd_valid      = (state_q == ST_WALK);
		clr_we        = (state_q == ST_CLEAR);
		load_out      = (state_q == ST_FINISH) && slot_free;
	end

	assign rd_addr       = {cur_y_q, cur_x_q};
	assign clr_addr      = clr_addr_q;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_count       = out_cnt_q;
	assign m_skipped     = out_skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			walk_all_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				walk_all_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cur_x_q <= in_sx;
			cur_y_q <= in_sy;
			end_x_q <= in_ex;
			end_y_q <= in_ey;
			skip_q  <= is_skip;
		end else if (rd_valid && !at_end) begin
			// x and y each move one step toward their end independently.
			if (cur_x_q != end_x_q) begin
				cur_x_q <= (cur_x_q < end_x_q) ? cur_x_q + coord_t'(1)
				                               : cur_x_q - coord_t'(1);
			end
			if (cur_y_q != end_y_q) begin
				cur_y_q <= (cur_y_q < end_y_q) ? cur_y_q + coord_t'(1)
				                               : cur_y_q - coord_t'(1);
			end
		end
		// The result beat may still be stalled when the next segment is taken,
		// so its payload is only replaced when a new beat is loaded.
		if (load_out) begin
			out_cnt_q  <= count;
			out_skip_q <= skip_q;
		end
	end

endmodule

// File: rtl/srovc_checker.sv
// ----------------------------------------------------------------------------
// Segment overlap counter checker
// Port-level assertions on the result stream and the reset clearing pass.
// ----------------------------------------------------------------------------
module srovc_checker
	import srovc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [OUT_TUSER_W-1:0] m_axis_tuser,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic                   cfg_data
);

	logic   out_acc;
	logic   have_prev_q;
	count_t last_cnt_q;

	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			last_cnt_q  <= '0;
		end else if (out_acc) begin
			have_prev_q <= 1'b1;
			last_cnt_q  <= m_axis_tdata[CNT_W-1:0];
		end
	end

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// A skipped segment leaves the overlap count as the previous beat showed it.
	a_skip_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_axis_tuser[0] && have_prev_q |->
			m_axis_tdata[CNT_W-1:0] == last_cnt_q)
		else $error("skipped segment changed the overlap count");

	// The clearing pass keeps the input closed right after reset.
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !s_axis_tready)
		else $error("input ready during clearing pass");

	// Padding above the count is always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:CNT_W] == '0)
		else $error("nonzero padding in result beat");

endmodule

bind segment_raster_overlap_counter srovc_checker u_srovc_checker (.*);
